### rtl/csd_pkg.sv
// Shared constants, control bundle and arctangent table for the concentric disk map.
`timescale 1ns / 1ps
package csd_pkg;

    localparam int GUARD = 24;
    localparam int QBITS = 31;
    localparam int ZW = 33;
    localparam logic [29:0] PI4_Q30 = 30'd843314857;
    localparam logic [29:0] KC_Q30 = 30'd652032874;

    typedef struct packed {
        logic       valid;
        logic [1:0] region;
        logic       neg;
        logic       den_zero;
    } csd_ctl_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0: v = 30'd843314857;
            5'd1: v = 30'd497837829;
            5'd2: v = 30'd263043837;
            5'd3: v = 30'd133525159;
            5'd4: v = 30'd67021687;
            5'd5: v = 30'd33543516;
            5'd6: v = 30'd16775851;
            5'd7: v = 30'd8388437;
            5'd8: v = 30'd4194283;
            5'd9: v = 30'd2097149;
            5'd31: v = 30'd1;
            default: v = 30'd1 << (5'd30 - idx);
        endcase
        return v;
    endfunction

endpackage

### rtl/concentric_square_to_disk_map_unit.sv
// Pipeline order: front register, division cells, angle register, CORDIC cells, quadrant register, output register.
// Throughput: one beat per cycle; the whole pipeline advances while the output register is free.
// The depth is set by the 31 division cells and the CORDIC_STAGES rotation cells besides the single registers above.
// in_ready drops only while a finished result waits in the output register.
// Reset clears every valid flag asynchronously; data registers are not reset.
`timescale 1ns / 1ps
module concentric_square_to_disk_map_unit #(
    parameter int IN_BITS = 16,
    parameter int OUT_BITS = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [IN_BITS-1:0]         square_x,
    input  logic [IN_BITS-1:0]         square_y,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [OUT_BITS-1:0] disk_x,
    output logic signed [OUT_BITS-1:0] disk_y
);
    import csd_pkg::*;

    localparam int CW = IN_BITS + GUARD + 3;
    localparam int S = IN_BITS + GUARD - OUT_BITS + 1;
    localparam logic [CW:0] ONE_W = 1;
    localparam logic signed [CW:0] RND = ONE_W << (S - 1);
    localparam logic signed [CW:0] SAT_HI = {{(CW + 2 - OUT_BITS){1'b0}}, {(OUT_BITS - 1){1'b1}}};
    localparam logic signed [CW:0] SAT_LO = {{(CW + 2 - OUT_BITS){1'b1}}, {(OUT_BITS - 1){1'b0}}};

    logic en;
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    // Front stage: region choice and magnitudes.
    logic signed [IN_BITS+1:0] a;
    logic signed [IN_BITS+1:0] b;
    logic signed [IN_BITS+1:0] nb;
    logic signed [IN_BITS+1:0] num;
    logic signed [IN_BITS+1:0] den;
    logic signed [IN_BITS+1:0] nnum;
    logic signed [IN_BITS+1:0] nden;
    logic [1:0]                region;
    logic                      neg0;
    csd_ctl_t                  ctl0_next;
    csd_ctl_t                  ctl0_reg;
    logic [IN_BITS:0]          un_reg;
    logic [IN_BITS:0]          ud_reg;

    always_comb
    begin
        a = $signed({1'b0, square_x, 1'b0}) - $signed({2'b01, {IN_BITS{1'b0}}});
        b = $signed({1'b0, square_y, 1'b0}) - $signed({2'b01, {IN_BITS{1'b0}}});
        nb = -b;
        if (a > nb)
        begin
            if (a > b)
            begin
                region = 2'd0;
                num = b;
                den = a;
                neg0 = 1'b0;
            end
            else
            begin
                region = 2'd1;
                num = a;
                den = b;
                neg0 = 1'b1;
            end
        end
        else
        begin
            if (a < b)
            begin
                region = 2'd2;
                num = b;
                den = a;
                neg0 = 1'b0;
            end
            else
            begin
                region = 2'd3;
                num = a;
                den = b;
                neg0 = 1'b1;
            end
        end
        nnum = -num;
        nden = -den;
        ctl0_next.valid = in_valid;
        ctl0_next.region = region;
        ctl0_next.den_zero = den == '0;
        ctl0_next.neg = neg0 ^ ((den != '0) & (num[IN_BITS+1] ^ den[IN_BITS+1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else if (en)
        begin
            ctl0_reg <= ctl0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            un_reg <= num[IN_BITS+1] ? nnum[IN_BITS:0] : num[IN_BITS:0];
            ud_reg <= den[IN_BITS+1] ? nden[IN_BITS:0] : den[IN_BITS:0];
        end
    end

    // Division chain.
    csd_ctl_t         dctl [QBITS+1];
    logic [IN_BITS:0] dud  [QBITS+1];
    logic [IN_BITS:0] drem [QBITS+1];
    logic [QBITS-1:0] dq   [QBITS+1];

    assign dctl[0] = ctl0_reg;
    assign dud[0] = ud_reg;
    assign drem[0] = un_reg;
    assign dq[0] = '0;

    for (genvar j = 0; j < QBITS; j++)
    begin : g_div
        csd_div_cell #(
            .IN_BITS(IN_BITS),
            .FIRST(j == 0)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .en(en),
            .ctl_in(dctl[j]),
            .ud_in(dud[j]),
            .rem_in(drem[j]),
            .q_in(dq[j]),
            .ctl_out(dctl[j+1]),
            .ud_out(dud[j+1]),
            .rem_out(drem[j+1]),
            .q_out(dq[j+1])
        );
    end

    // Angle and start vector.
    logic [QBITS-1:0]         qm;
    logic [QBITS+29:0]        tprod;
    logic [QBITS+29:0]        tsum;
    logic signed [ZW-1:0]     tval;
    logic [IN_BITS+30:0]      xprod;
    logic [IN_BITS+30:0]      xsum;
    csd_ctl_t                 mctl_reg;
    logic signed [ZW-1:0]     z0_reg;
    logic signed [CW-1:0]     x0_reg;

    always_comb
    begin
        qm = dctl[QBITS].den_zero ? '0 : dq[QBITS];
        tprod = (QBITS + 30)'(qm) * (QBITS + 30)'(PI4_Q30);
        tsum = tprod + ((QBITS + 30)'(1) << 29);
        tval = $signed(ZW'(tsum >> 30));
        xprod = (IN_BITS + 31)'(dud[QBITS]) * (IN_BITS + 31)'(KC_Q30);
        xsum = xprod + (IN_BITS + 31)'(32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mctl_reg <= '0;
        end
        else if (en)
        begin
            mctl_reg <= dctl[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg <= dctl[QBITS].neg ? -tval : tval;
            x0_reg <= $signed(CW'(xsum >> 6));
        end
    end

    // CORDIC chain.
    csd_ctl_t             cctl [CORDIC_STAGES+1];
    logic signed [CW-1:0] cx   [CORDIC_STAGES+1];
    logic signed [CW-1:0] cy   [CORDIC_STAGES+1];
    logic signed [ZW-1:0] cz   [CORDIC_STAGES+1];

    assign cctl[0] = mctl_reg;
    assign cx[0] = x0_reg;
    assign cy[0] = '0;
    assign cz[0] = z0_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        csd_cordic_cell #(
            .CW(CW),
            .STAGE(i)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .en(en),
            .ctl_in(cctl[i]),
            .x_in(cx[i]),
            .y_in(cy[i]),
            .z_in(cz[i]),
            .ctl_out(cctl[i+1]),
            .x_out(cx[i+1]),
            .y_out(cy[i+1]),
            .z_out(cz[i+1])
        );
    end

    // Quadrant offset.
    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;
    logic                 sv_reg;
    logic signed [CW-1:0] sx_reg;
    logic signed [CW-1:0] sy_reg;

    assign xe = cx[CORDIC_STAGES];
    assign ye = cy[CORDIC_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg <= cctl[CORDIC_STAGES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (cctl[CORDIC_STAGES].region)
                2'd1:
                begin
                    sx_reg <= -ye;
                    sy_reg <= xe;
                end
                2'd2:
                begin
                    sx_reg <= -xe;
                    sy_reg <= -ye;
                end
                2'd3:
                begin
                    sx_reg <= ye;
                    sy_reg <= -xe;
                end
                default:
                begin
                    sx_reg <= xe;
                    sy_reg <= ye;
                end
            endcase
        end
    end

    // Rounding, saturation and output register.
    logic signed [CW:0]         rx;
    logic signed [CW:0]         ry;
    logic signed [CW:0]         qx;
    logic signed [CW:0]         qy;
    logic signed [OUT_BITS-1:0] fx;
    logic signed [OUT_BITS-1:0] fy;
    logic                       out_valid_reg;
    logic signed [OUT_BITS-1:0] disk_x_reg;
    logic signed [OUT_BITS-1:0] disk_y_reg;

    always_comb
    begin
        rx = $signed({sx_reg[CW-1], sx_reg}) + RND;
        ry = $signed({sy_reg[CW-1], sy_reg}) + RND;
        qx = rx >>> S;
        qy = ry >>> S;
        if (qx > SAT_HI)
        begin
            fx = SAT_HI[OUT_BITS-1:0];
        end
        else if (qx < SAT_LO)
        begin
            fx = SAT_LO[OUT_BITS-1:0];
        end
        else
        begin
            fx = qx[OUT_BITS-1:0];
        end
        if (qy > SAT_HI)
        begin
            fy = SAT_HI[OUT_BITS-1:0];
        end
        else if (qy < SAT_LO)
        begin
            fy = SAT_LO[OUT_BITS-1:0];
        end
        else
        begin
            fy = qy[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disk_x_reg <= fx;
            disk_y_reg <= fy;
        end
    end

    assign out_valid = out_valid_reg;
    assign disk_x = disk_x_reg;
    assign disk_y = disk_y_reg;
endmodule

### rtl/csd_div_cell.sv
// One restoring division cell: produces one quotient bit per beat.
`timescale 1ns / 1ps
module csd_div_cell #(
    parameter int IN_BITS = 16,
    parameter bit FIRST = 1'b0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  csd_pkg::csd_ctl_t       ctl_in,
    input  logic [IN_BITS:0]        ud_in,
    input  logic [IN_BITS:0]        rem_in,
    input  logic [csd_pkg::QBITS-1:0] q_in,
    output csd_pkg::csd_ctl_t       ctl_out,
    output logic [IN_BITS:0]        ud_out,
    output logic [IN_BITS:0]        rem_out,
    output logic [csd_pkg::QBITS-1:0] q_out
);
    import csd_pkg::*;

    logic [IN_BITS+1:0] part;
    logic               ge;
    logic [IN_BITS+1:0] diff;
    csd_ctl_t           ctl_reg;
    logic [IN_BITS:0]   ud_reg;
    logic [IN_BITS:0]   rem_reg;
    logic [QBITS-1:0]   q_reg;
    logic [IN_BITS:0]   rem_next;

    always_comb
    begin
        part = FIRST ? {1'b0, rem_in} : {rem_in, 1'b0};
        ge = part >= {1'b0, ud_in};
        diff = part - {1'b0, ud_in};
        rem_next = ge ? diff[IN_BITS:0] : part[IN_BITS:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ud_reg <= ud_in;
            rem_reg <= rem_next;
            q_reg <= {q_in[QBITS-2:0], ge};
        end
    end

    assign ctl_out = ctl_reg;
    assign ud_out = ud_reg;
    assign rem_out = rem_reg;
    assign q_out = q_reg;
endmodule

### rtl/csd_cordic_cell.sv
// One CORDIC rotation cell with a fixed shift and arctangent constant.
`timescale 1ns / 1ps
module csd_cordic_cell #(
    parameter int CW = 43,
    parameter int STAGE = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  csd_pkg::csd_ctl_t          ctl_in,
    input  logic signed [CW-1:0]       x_in,
    input  logic signed [CW-1:0]       y_in,
    input  logic signed [csd_pkg::ZW-1:0] z_in,
    output csd_pkg::csd_ctl_t          ctl_out,
    output logic signed [CW-1:0]       x_out,
    output logic signed [CW-1:0]       y_out,
    output logic signed [csd_pkg::ZW-1:0] z_out
);
    import csd_pkg::*;

    localparam logic signed [ZW-1:0] ANG = ZW'(atan_q30(5'(STAGE)));

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    csd_ctl_t             ctl_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;

    assign dx = y_in >>> STAGE;
    assign dy = x_in >>> STAGE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!z_in[ZW-1])
            begin
                x_reg <= x_in - dx;
                y_reg <= y_in + dy;
                z_reg <= z_in - ANG;
            end
            else
            begin
                x_reg <= x_in + dx;
                y_reg <= y_in - dy;
                z_reg <= z_in + ANG;
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

### rtl/csd_checker.sv
// Port-level checks for the concentric disk map unit, attached by bind.
`timescale 1ns / 1ps
module csd_checker #(
    parameter int IN_BITS = 16,
    parameter int OUT_BITS = 16
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [IN_BITS-1:0]  square_x,
    input logic [IN_BITS-1:0]  square_y,
    input logic                out_valid,
    input logic                out_ready,
    input logic [OUT_BITS-1:0] disk_x,
    input logic [OUT_BITS-1:0] disk_y
);
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(square_x) && $stable(square_y))
        else $error("Waiting input beat was withdrawn or changed.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Output beat dropped before it was taken.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(disk_x) && $stable(disk_y))
        else $error("Stalled output beat changed.");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("Input stalled while the output register is empty.");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("Input taken while the output register is blocked.");
endmodule

bind concentric_square_to_disk_map_unit csd_checker #(
    .IN_BITS(IN_BITS),
    .OUT_BITS(OUT_BITS)
) u_csd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .square_x(square_x),
    .square_y(square_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .disk_x(disk_x),
    .disk_y(disk_y)
);

### verif/concentric_square_to_disk_map_unit_test.sv
// Self-checking testbench for the concentric square-to-disk map unit with a bit-exact predictor.
`timescale 1ns / 1ps
module concentric_square_to_disk_map_unit_test;

    localparam int IN_BITS = 16;
    localparam int OUT_BITS = 16;
    localparam int STAGES = 16;
    localparam int GUARD_BITS = 24;
    localparam int LATENCY = STAGES + 35;
    localparam longint PI_QUARTER = 843314857;
    localparam longint GAIN_COMP = 652032874;
    localparam int DIRECTED_ROWS = 20;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [15:0] px;
        logic [15:0] py;
        logic        known;
        logic [15:0] ex;
        logic [15:0] ey;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [IN_BITS-1:0] square_x = '0;
    logic [IN_BITS-1:0] square_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [OUT_BITS-1:0] disk_x;
    logic signed [OUT_BITS-1:0] disk_y;

    logic [31:0] disk_points_pending[$];
    longint arctan_table[32];
    int error_count = 0;
    int cycle_count = 0;
    bit stimulus_done = 1'b0;
    bit calm_phase = 1'b0;
    bit long_hold = 1'b0;
    stim_row_t directed_rows[DIRECTED_ROWS];

    concentric_square_to_disk_map_unit #(
        .IN_BITS(IN_BITS),
        .OUT_BITS(OUT_BITS),
        .CORDIC_STAGES(STAGES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .square_x(square_x),
        .square_y(square_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .disk_x(disk_x),
        .disk_y(disk_y)
    );

    always #5 clk = ~clk;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] round_saturate(longint v);
        int s;
        longint q;
        s = IN_BITS + GUARD_BITS - OUT_BITS + 1;
        q = floor_shr(v + (longint'(1) << (s - 1)), s);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic void build_arctan_table();
        for (int i = 0; i < 32; i++)
        begin
            logic [63:0] acc;
            acc = 64'h3243F6A8885A308D;
            if (i != 0)
            begin
                acc = 0;
                for (int k = 0; 62 - (2 * k + 1) * i >= 0; k++)
                begin
                    logic [63:0] term;
                    term = (64'd1 << (62 - (2 * k + 1) * i)) / (2 * k + 1);
                    if (k % 2 == 0)
                        acc = acc + term;
                    else
                        acc = acc - term;
                end
            end
            arctan_table[i] = longint'((acc + (64'd1 << 31)) >> 32);
        end
    endfunction

    function automatic logic [31:0] map_to_disk(logic [15:0] sx, logic [15:0] sy);
        longint a, b, r, num, den, x, y, z, t, dx, dy, tmp;
        logic [63:0] mag, un, ud;
        int region;
        bit neg;
        a = 2 * longint'(sx) - 65536;
        b = 2 * longint'(sy) - 65536;
        if (a > -b)
        begin
            if (a > b)
            begin
                region = 0; r = a; num = b; den = a; neg = 0;
            end
            else
            begin
                region = 1; r = b; num = a; den = b; neg = 1;
            end
        end
        else
        begin
            if (a < b)
            begin
                region = 2; r = -a; num = b; den = a; neg = 0;
            end
            else
            begin
                region = 3; r = -b; num = a; den = b; neg = 1;
            end
        end
        mag = 0;
        if (den != 0)
        begin
            un = (num < 0) ? -num : num;
            ud = (den < 0) ? -den : den;
            mag = (un << 30) / ud;
            if (num < 0)
                neg = ~neg;
            if (den < 0)
                neg = ~neg;
        end
        t = longint'((mag * PI_QUARTER + (64'd1 << 29)) >> 30);
        z = neg ? -t : t;
        x = longint'((r * GAIN_COMP + 32) >>> 6);
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan_table[i];
            end
            else
            begin
                x += dx; y -= dy; z += arctan_table[i];
            end
        end
        case (region)
            1: begin tmp = x; x = -y; y = tmp; end
            2: begin x = -x; y = -y; end
            3: begin tmp = x; x = y; y = -tmp; end
            default: ;
        endcase
        return {round_saturate(x), round_saturate(y)};
    endfunction

    task automatic send_point(logic [15:0] sx, logic [15:0] sy);
        int gap;
        if (!calm_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        square_x <= sx;
        square_y <= sy;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        disk_points_pending.insert(disk_points_pending.size(), map_to_disk(sx, sy));
        @(negedge clk);
    endtask

    initial
    begin
        directed_rows[0] = '{16'h8000, 16'h8000, 1'b1, 16'h0000, 16'h0000};
        directed_rows[1] = '{16'h0000, 16'h8000, 1'b0, 16'h0, 16'h0};
        directed_rows[2] = '{16'h8000, 16'h0000, 1'b0, 16'h0, 16'h0};
        directed_rows[3] = '{16'h0000, 16'h0000, 1'b0, 16'h0, 16'h0};
        directed_rows[4] = '{16'hFFFF, 16'hFFFF, 1'b0, 16'h0, 16'h0};
        directed_rows[5] = '{16'h0000, 16'hFFFF, 1'b0, 16'h0, 16'h0};
        directed_rows[6] = '{16'hFFFF, 16'h0000, 1'b0, 16'h0, 16'h0};
        directed_rows[7] = '{16'hFFFF, 16'h8000, 1'b0, 16'h0, 16'h0};
        directed_rows[8] = '{16'h8000, 16'hFFFF, 1'b0, 16'h0, 16'h0};
        directed_rows[9] = '{16'h8001, 16'h8000, 1'b0, 16'h0, 16'h0};
        directed_rows[10] = '{16'h7FFF, 16'h8000, 1'b0, 16'h0, 16'h0};
        directed_rows[11] = '{16'h8000, 16'h8001, 1'b0, 16'h0, 16'h0};
        directed_rows[12] = '{16'h8000, 16'h7FFF, 1'b0, 16'h0, 16'h0};
        directed_rows[13] = '{16'hC000, 16'hC000, 1'b0, 16'h0, 16'h0};
        directed_rows[14] = '{16'h4000, 16'hC000, 1'b0, 16'h0, 16'h0};
        directed_rows[15] = '{16'h4000, 16'h4000, 1'b0, 16'h0, 16'h0};
        directed_rows[16] = '{16'hC000, 16'h4000, 1'b0, 16'h0, 16'h0};
        directed_rows[17] = '{16'h5555, 16'hAAAA, 1'b0, 16'h0, 16'h0};
        directed_rows[18] = '{16'hAAAA, 16'h5555, 1'b0, 16'h0, 16'h0};
        directed_rows[19] = '{16'h0001, 16'hFFFE, 1'b0, 16'h0, 16'h0};
        build_arctan_table();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].known &&
                map_to_disk(directed_rows[i].px, directed_rows[i].py) !=
                {directed_rows[i].ex, directed_rows[i].ey})
            begin
                $display("%0t directed row %0d: expected %h actual %h", $time, i,
                         {directed_rows[i].ex, directed_rows[i].ey},
                         map_to_disk(directed_rows[i].px, directed_rows[i].py));
                error_count++;
            end
            send_point(directed_rows[i].px, directed_rows[i].py);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 300)
                long_hold = 1'b1;
            if (n == RANDOM_ITEMS - 200)
                calm_phase = 1'b1;
            send_point(16'($urandom), 16'($urandom));
        end
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (!calm_phase && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (disk_points_pending.size() == 0)
            begin
                $display("%0t unexpected beat: expected none actual %h %h", $time,
                         disk_x, disk_y);
                error_count++;
            end
            else
            begin
                want = disk_points_pending.pop_front();
                if (disk_x !== want[31:16])
                begin
                    $display("%0t disk_x: expected %h actual %h", $time, want[31:16], disk_x);
                    error_count++;
                end
                if (disk_y !== want[15:0])
                begin
                    $display("%0t disk_y: expected %h actual %h", $time, want[15:0], disk_y);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        wait (stimulus_done);
        wait (disk_points_pending.size() == 0);
        repeat (2 * LATENCY) @(posedge clk);
        if (error_count == 0)
            $display("concentric_square_to_disk_map_unit_test: clean");
        else
            $display("concentric_square_to_disk_map_unit_test: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("concentric_square_to_disk_map_unit_test: errors");
            $finish;
        end
    end

endmodule
